/* rtl/tme_pkg.sv */
// Package for the tag matching engine: payload structs, status codes, cell views.
// No dependencies.
`timescale 1ns / 1ps
package tme_pkg;

	localparam logic [1:0] ST_MATCH = 2'd0;
	localparam logic [1:0] ST_STORED = 2'd1;
	localparam logic [1:0] ST_DROPPED = 2'd2;

	localparam logic ACT_POST = 1'b0;
	localparam logic ACT_ARRIVE = 1'b1;

	typedef struct packed {
		logic        action;
		logic        tagged_req;
		logic [63:0] tag;
		logic [63:0] ignore_mask;
		logic [15:0] peer;
		logic        any_peer;
		logic [15:0] handle;
		logic [31:0] length;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  match_status;
		logic [15:0] recv_handle;
		logic [15:0] msg_handle;
		logic [15:0] msg_peer;
		logic [63:0] msg_tag;
		logic [31:0] deliver_len;
		logic        truncated;
		logic        was_tagged;
	} out_item_t;

	// Control from the top level to every cell of one table.
	typedef struct packed {
		logic search;  // compare the key against the stored entry
		logic remove;  // close up the gap at the first hit
		logic append;  // write the key into the first free cell
	} cell_ctl_t;

endpackage

/* rtl/tag_matching_engine.sv */
// Top level of the tag matching engine: input register, two cell-chain tables,
// output register. Depends on tme_pkg and tme_table.
`timescale 1ns / 1ps
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries posts (action 0)
//   and message arrivals (action 1). The output channel (out_valid,
//   out_stall, out_data) returns exactly one result per item.
//   Flow: an item is taken into a register, searched against every cell
//   of the opposite table in the next cycle, and its result is registered at
//   the end of that cycle.
//   The block takes no new item until the result of the last one has left:
//   the input stays stalled through the search cycle and while the result
//   waits, and the close-up of the cell chain must finish before the next search.
//   A stalled receiver holds the result steady and stops further intake.
//   Reset clears all valid bits of both tables and empties the pipeline;
//   stored data words need no clearing.
module tag_matching_engine #(
	parameter int POSTED_DEPTH = 64,
	parameter int UNEXP_DEPTH = 64,
	parameter int PEER_BITS = 16,
	parameter int HANDLE_BITS = 16,
	parameter int LEN_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  tme_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output tme_pkg::out_item_t  out_data
);
	import tme_pkg::*;

	in_item_t item_q;
	logic busy_q, out_valid_q;
	out_item_t out_q, out_d;
	cell_ctl_t pctl, uctl;
	logic p_hit, p_full, u_hit, u_full, hit, arrive;
	logic [63:0] p_tag, u_tag;
	logic [PEER_BITS-1:0] p_peer, u_peer, kpeer;
	logic [HANDLE_BITS-1:0] p_hnd, u_hnd, khnd;
	logic [LEN_BITS-1:0] p_len, u_len, klen, size, cap, dlen;

	assign in_stall = busy_q || out_valid_q;
	assign arrive = (item_q.action == ACT_ARRIVE);
	assign kpeer = PEER_BITS'(item_q.peer);
	assign khnd = HANDLE_BITS'(item_q.handle);
	assign klen = LEN_BITS'(item_q.length);

	// Table control: search and close up the opposite table, append to the own table on a miss.
	always_comb begin
		pctl = '0;
		uctl = '0;
		if (busy_q) begin
			pctl.search = arrive;
			pctl.remove = arrive;
			uctl.search = !arrive;
			uctl.remove = !arrive;
			pctl.append = !arrive && !u_hit && !p_full;
			uctl.append = arrive && !p_hit && !u_full;
		end
	end

	tme_table #(
		.DEPTH(POSTED_DEPTH), .PEER_BITS(PEER_BITS), .HANDLE_BITS(HANDLE_BITS),
		.LEN_BITS(LEN_BITS), .IS_POST(1'b1)
	) u_post (
		.clk(clk), .arst_n(arst_n), .ctl(pctl), .key_tagged(item_q.tagged_req),
		.key_tag(item_q.tag), .key_ignore(item_q.ignore_mask), .key_peer(kpeer),
		.key_any(item_q.any_peer), .key_handle(khnd), .key_len(klen),
		.any_hit(p_hit), .full(p_full), .sel_tag(p_tag), .sel_peer(p_peer),
		.sel_handle(p_hnd), .sel_len(p_len)
	);

	tme_table #(
		.DEPTH(UNEXP_DEPTH), .PEER_BITS(PEER_BITS), .HANDLE_BITS(HANDLE_BITS),
		.LEN_BITS(LEN_BITS), .IS_POST(1'b0)
	) u_unexp (
		.clk(clk), .arst_n(arst_n), .ctl(uctl), .key_tagged(item_q.tagged_req),
		.key_tag(item_q.tag), .key_ignore(item_q.ignore_mask), .key_peer(kpeer),
		.key_any(item_q.any_peer), .key_handle(khnd), .key_len(klen),
		.any_hit(u_hit), .full(u_full), .sel_tag(u_tag), .sel_peer(u_peer),
		.sel_handle(u_hnd), .sel_len(u_len)
	);

	// Result assembly.
	assign hit = arrive ? p_hit : u_hit;
	assign size = arrive ? klen : u_len;
	assign cap = arrive ? p_len : klen;
	assign dlen = (size < cap) ? size : cap;

	always_comb begin
		out_d = '0;
		if (hit) begin
			out_d.match_status = ST_MATCH;
			out_d.recv_handle = 16'(arrive ? p_hnd : khnd);
			out_d.msg_handle = 16'(arrive ? khnd : u_hnd);
			out_d.msg_peer = 16'(arrive ? kpeer : u_peer);
			out_d.msg_tag = item_q.tagged_req ? (arrive ? item_q.tag : u_tag) : 64'd0;
			out_d.deliver_len = 32'(dlen);
			out_d.truncated = size > cap;
			out_d.was_tagged = item_q.tagged_req;
		end else if (arrive ? u_full : p_full) begin
			out_d.match_status = ST_DROPPED;
		end else begin
			out_d.match_status = ST_STORED;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				busy_q <= 1'b0;
			end
			if (busy_q) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_q <= in_data;
		end
		if (busy_q) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

`ifndef SYNTH
	// A search never overlaps a waiting result.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && out_valid_q)) else $error("search overlaps pending result");
	// Every search yields a result in the next cycle.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> out_valid_q) else $error("search lost its result");
	// A table never appends and removes at once.
	a_ctl: assert property (@(posedge clk) disable iff (!arst_n)
		!(pctl.append && pctl.remove) && !(uctl.append && uctl.remove))
		else $error("append and remove together");
`endif
endmodule

/* rtl/tme_cell.sv */
// One entry of a match table: a stored item, its match test and its shift logic.
// Depends on tme_pkg.
`timescale 1ns / 1ps
module tme_cell #(
	parameter int PEER_BITS = 16,
	parameter int HANDLE_BITS = 16,
	parameter int LEN_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tme_pkg::cell_ctl_t     ctl,
	input  logic                   is_post_tab,
	input  logic                   key_tagged,
	input  logic [63:0]            key_tag,
	input  logic [63:0]            key_ignore,
	input  logic [PEER_BITS-1:0]   key_peer,
	input  logic                   key_any,
	input  logic [HANDLE_BITS-1:0] key_handle,
	input  logic [LEN_BITS-1:0]    key_len,
	// Hit chain: any older cell already hit.
	input  logic                   hit_before,
	// Next (younger) cell's contents, shifted in when closing up.
	input  logic                   nxt_valid,
	input  logic                   nxt_tagged,
	input  logic                   nxt_any,
	input  logic [63:0]            nxt_tag,
	input  logic [63:0]            nxt_ignore,
	input  logic [PEER_BITS-1:0]   nxt_peer,
	input  logic [HANDLE_BITS-1:0] nxt_handle,
	input  logic [LEN_BITS-1:0]    nxt_len,
	input  logic                   prev_valid,
	output logic                   valid,
	output logic                   is_tagged,
	output logic                   anyp,
	output logic [63:0]            tag,
	output logic [63:0]            ignore,
	output logic [PEER_BITS-1:0]   peer,
	output logic [HANDLE_BITS-1:0] handle,
	output logic [LEN_BITS-1:0]    len,
	output logic                   hit,
	output logic                   hit_after
);
	import tme_pkg::*;

	logic valid_q, tagged_q, any_q, match;
	logic [63:0] tag_q, ign_q, rtag, mtag, ign;
	logic [PEER_BITS-1:0] peer_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [LEN_BITS-1:0] len_q;

	// Match test; the receive side supplies the ignore mask and the wildcard.
	always_comb begin
		rtag = is_post_tab ? tag_q : key_tag;
		mtag = is_post_tab ? key_tag : tag_q;
		ign = is_post_tab ? ign_q : key_ignore;
		match = valid_q && (tagged_q == key_tagged)
			&& ((is_post_tab ? any_q : key_any) || (peer_q == key_peer))
			&& (!key_tagged || (((rtag ^ mtag) & ~ign) == 64'd0));
	end

	assign hit = ctl.search && match && !hit_before;
	assign hit_after = hit_before || (ctl.search && match);

	// Valid bit: shifts with the entry on removal, set on append.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.remove && hit_after) begin
			valid_q <= nxt_valid;
		end else if (ctl.append && !valid_q && prev_valid) begin
			valid_q <= 1'b1;
		end
	end

	// Entry data.
	always_ff @(posedge clk) begin
		if (ctl.remove && hit_after) begin
			tagged_q <= nxt_tagged;
			any_q <= nxt_any;
			tag_q <= nxt_tag;
			ign_q <= nxt_ignore;
			peer_q <= nxt_peer;
			handle_q <= nxt_handle;
			len_q <= nxt_len;
		end else if (ctl.append && !valid_q && prev_valid) begin
			tagged_q <= key_tagged;
			any_q <= key_any;
			tag_q <= key_tag;
			ign_q <= key_ignore;
			peer_q <= key_peer;
			handle_q <= key_handle;
			len_q <= key_len;
		end
	end

	assign valid = valid_q;
	assign is_tagged = tagged_q;
	assign anyp = any_q;
	assign tag = tag_q;
	assign ignore = ign_q;
	assign peer = peer_q;
	assign handle = handle_q;
	assign len = len_q;
endmodule

/* rtl/tme_table.sv */
// A match table built as a chain of cells, with the hit entry selected out.
// Depends on tme_pkg and tme_cell.
`timescale 1ns / 1ps
module tme_table #(
	parameter int DEPTH = 64,
	parameter int PEER_BITS = 16,
	parameter int HANDLE_BITS = 16,
	parameter int LEN_BITS = 32,
	parameter bit IS_POST = 1'b1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tme_pkg::cell_ctl_t     ctl,
	input  logic                   key_tagged,
	input  logic [63:0]            key_tag,
	input  logic [63:0]            key_ignore,
	input  logic [PEER_BITS-1:0]   key_peer,
	input  logic                   key_any,
	input  logic [HANDLE_BITS-1:0] key_handle,
	input  logic [LEN_BITS-1:0]    key_len,
	output logic                   any_hit,
	output logic                   full,
	output logic [63:0]            sel_tag,
	output logic [PEER_BITS-1:0]   sel_peer,
	output logic [HANDLE_BITS-1:0] sel_handle,
	output logic [LEN_BITS-1:0]    sel_len
);
	import tme_pkg::*;

	logic [DEPTH:0] v, tg, an, hchain;
	logic [DEPTH-1:0] hit;
	logic [63:0] tagv [DEPTH+1];
	logic [63:0] ignv [DEPTH+1];
	logic [PEER_BITS-1:0] peerv [DEPTH+1];
	logic [HANDLE_BITS-1:0] hndv [DEPTH+1];
	logic [LEN_BITS-1:0] lenv [DEPTH+1];

	// Beyond the last cell the chain ends in an empty entry.
	assign v[DEPTH] = 1'b0;
	assign tg[DEPTH] = 1'b0;
	assign an[DEPTH] = 1'b0;
	assign tagv[DEPTH] = '0;
	assign ignv[DEPTH] = '0;
	assign peerv[DEPTH] = '0;
	assign hndv[DEPTH] = '0;
	assign lenv[DEPTH] = '0;
	assign hchain[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		tme_cell #(
			.PEER_BITS(PEER_BITS), .HANDLE_BITS(HANDLE_BITS), .LEN_BITS(LEN_BITS)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl), .is_post_tab(IS_POST),
			.key_tagged(key_tagged), .key_tag(key_tag), .key_ignore(key_ignore),
			.key_peer(key_peer), .key_any(key_any), .key_handle(key_handle),
			.key_len(key_len), .hit_before(hchain[i]),
			.nxt_valid(v[i+1]), .nxt_tagged(tg[i+1]), .nxt_any(an[i+1]),
			.nxt_tag(tagv[i+1]), .nxt_ignore(ignv[i+1]), .nxt_peer(peerv[i+1]),
			.nxt_handle(hndv[i+1]), .nxt_len(lenv[i+1]),
			.prev_valid((i == 0) ? 1'b1 : v[(i == 0) ? 0 : i-1]),
			.valid(v[i]), .is_tagged(tg[i]), .anyp(an[i]), .tag(tagv[i]),
			.ignore(ignv[i]), .peer(peerv[i]), .handle(hndv[i]), .len(lenv[i]),
			.hit(hit[i]), .hit_after(hchain[i+1])
		);
	end

	assign any_hit = hchain[DEPTH];
	assign full = v[DEPTH-1];

	// One-hot select of the hit entry.
	always_comb begin
		sel_tag = '0;
		sel_peer = '0;
		sel_handle = '0;
		sel_len = '0;
		for (int k = 0; k < DEPTH; k++) begin
			sel_tag = sel_tag | (tagv[k] & {64{hit[k]}});
			sel_peer = sel_peer | (peerv[k] & {PEER_BITS{hit[k]}});
			sel_handle = sel_handle | (hndv[k] & {HANDLE_BITS{hit[k]}});
			sel_len = sel_len | (lenv[k] & {LEN_BITS{hit[k]}});
		end
	end
endmodule

/* sim/tag_matching_engine_tb.sv */
// Testbench for the tag matching engine: predicts each match, store or drop
// result with its own copy of both tables and checks the results in order.
// Depends on tme_pkg and the tag_matching_engine RTL.
`timescale 1ns / 1ps
module tag_matching_engine_tb;
	import tme_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int CYCLE_LIMIT = 400000;

	// Model of the two ordered tables and the queue of expected results.
	class match_scoreboard;
		in_item_t posted[$];
		in_item_t unexpected[$];
		out_item_t pending[$];
		int errors;
		int hit_count;
		int drops;

		function void note_transfer(in_item_t it);
			out_item_t r;
			in_item_t e;
			bit hit;
			int i;
			r = '0;
			hit = 0;
			if (it.action == ACT_ARRIVE) begin
				for (i = 0; i < posted.size() && !hit; i++) begin
					e = posted[i];
					if (e.tagged_req != it.tagged_req) continue;
					if (!e.any_peer && e.peer != it.peer) continue;
					if (it.tagged_req && (((e.tag ^ it.tag) & ~e.ignore_mask) != 0))
						continue;
					hit = 1;
					r.recv_handle = e.handle;
					r.msg_handle = it.handle;
					r.msg_peer = it.peer;
					r.msg_tag = it.tagged_req ? it.tag : 64'd0;
					r.deliver_len = (it.length < e.length) ? it.length : e.length;
					r.truncated = it.length > e.length;
					posted.delete(i);
				end
				if (!hit) begin
					if (unexpected.size() >= TABLE_DEPTH) r.match_status = ST_DROPPED;
					else begin
						unexpected.push_back(it);
						r.match_status = ST_STORED;
					end
				end
			end else begin
				for (i = 0; i < unexpected.size() && !hit; i++) begin
					e = unexpected[i];
					if (e.tagged_req != it.tagged_req) continue;
					if (!it.any_peer && e.peer != it.peer) continue;
					if (it.tagged_req && (((e.tag ^ it.tag) & ~it.ignore_mask) != 0))
						continue;
					hit = 1;
					r.recv_handle = it.handle;
					r.msg_handle = e.handle;
					r.msg_peer = e.peer;
					r.msg_tag = it.tagged_req ? e.tag : 64'd0;
					r.deliver_len = (e.length < it.length) ? e.length : it.length;
					r.truncated = e.length > it.length;
					unexpected.delete(i);
				end
				if (!hit) begin
					if (posted.size() >= TABLE_DEPTH) r.match_status = ST_DROPPED;
					else begin
						posted.push_back(it);
						r.match_status = ST_STORED;
					end
				end
			end
			if (hit) begin
				r.match_status = ST_MATCH;
				r.was_tagged = it.tagged_req;
				hit_count++;
			end
			if (r.match_status == ST_DROPPED) drops++;
			pending.push_back(r);
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.match_status != exp.match_status)
				report("match_status", 64'(exp.match_status), 64'(got.match_status));
			if (got.recv_handle != exp.recv_handle)
				report("recv_handle", 64'(exp.recv_handle), 64'(got.recv_handle));
			if (got.msg_handle != exp.msg_handle)
				report("msg_handle", 64'(exp.msg_handle), 64'(got.msg_handle));
			if (got.msg_peer != exp.msg_peer)
				report("msg_peer", 64'(exp.msg_peer), 64'(got.msg_peer));
			if (got.msg_tag != exp.msg_tag)
				report("msg_tag", exp.msg_tag, got.msg_tag);
			if (got.deliver_len != exp.deliver_len)
				report("deliver_len", 64'(exp.deliver_len), 64'(got.deliver_len));
			if (got.truncated != exp.truncated)
				report("truncated", 64'(exp.truncated), 64'(got.truncated));
			if (got.was_tagged != exp.was_tagged)
				report("was_tagged", 64'(exp.was_tagged), 64'(got.was_tagged));
		endfunction

		function void report(string field, logic [63:0] exp, logic [63:0] got);
			$display("%0t: %s expected %h actual %h", $time, field, exp, got);
			errors++;
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	out_item_t out_data;
	logic long_hold = 0;
	int cycles = 0;
	match_scoreboard sb = new();

	tag_matching_engine i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Note input transfers and check output transfers at the clock edge.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) sb.note_transfer(in_data);
		if (arst_n && out_valid && !out_stall) sb.check_result(out_data);
	end

	// Receiver stall pattern, with one long hold-off when asked.
	always @(posedge clk) begin
		int mode;
		mode = (cycles / 500) % 3;
		if (long_hold) out_stall <= 1;
		else if (mode == 0) out_stall <= 0;
		else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
		else out_stall <= ($urandom_range(0, 1) == 0);
	end

	// Small pools of tags and peers for well-formed items, so that random items often match.
	function automatic in_item_t random_item(int well_formed);
		in_item_t it;
		it.action = 1'($urandom_range(0, 1));
		it.tagged_req = 1'($urandom_range(0, 1));
		it.any_peer = ($urandom_range(0, 3) == 0);
		if (well_formed) begin
			it.tag = {32'($urandom_range(0, 3)), 29'd0, 3'($urandom_range(0, 7))};
			it.peer = 16'($urandom_range(0, 3));
			it.ignore_mask = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd0;
		end else begin
			it.tag = {$urandom, $urandom};
			it.peer = 16'($urandom);
			it.ignore_mask = {$urandom, $urandom};
		end
		it.handle = 16'($urandom);
		it.length = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 300) : $urandom;
		return it;
	endfunction

	// Offer one item and hold it until the block takes it.
	task automatic send_item(in_item_t it);
		in_valid <= 1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic idle_cycles(int n);
		in_valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	function automatic in_item_t make_item(logic act, logic tg, logic [63:0] t,
			logic [63:0] m, logic [15:0] p, logic ap, logic [15:0] h, logic [31:0] l);
		in_item_t it;
		it.action = act; it.tagged_req = tg; it.tag = t; it.ignore_mask = m;
		it.peer = p; it.any_peer = ap; it.handle = h; it.length = l;
		return it;
	endfunction

	initial begin
		in_item_t it;
		int burst;
		int i;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, both classes, wildcards, masks, truncation.
		send_item(make_item(ACT_POST, 1, '1, '0, 16'hFFFF, 0, 16'hFFFF, 32'hFFFFFFFF));
		send_item(make_item(ACT_ARRIVE, 1, '1, '1, 16'hFFFF, 1, 16'hFFFF, 32'hFFFFFFFF));
		send_item(make_item(ACT_ARRIVE, 1, '0, '0, 16'h0, 0, 16'h0, 32'h0));
		send_item(make_item(ACT_POST, 1, '1, '1, 16'h0, 0, 16'h1, 32'h10));
		send_item(make_item(ACT_ARRIVE, 0, 64'h5, '0, 16'h7, 0, 16'h2, 32'h20));
		send_item(make_item(ACT_POST, 0, 64'h9, '1, 16'h3, 1, 16'h3, 32'h8));
		send_item(make_item(ACT_POST, 1, 64'hAAAA, 64'hFF, 16'h4, 0, 16'h4, 32'h40));
		send_item(make_item(ACT_ARRIVE, 1, 64'hAA55, '0, 16'h5, 0, 16'h5, 32'h40));
		send_item(make_item(ACT_ARRIVE, 1, 64'hAA55, '0, 16'h4, 0, 16'h6, 32'h41));
		send_item(make_item(ACT_POST, 1, 64'h1, '0, 16'h9, 1, 16'h7, 32'h0));
		send_item(make_item(ACT_ARRIVE, 1, 64'h1, '1, 16'h8, 1, 16'h8, 32'h0));
		// Fill the posted table past full, then drain it with arrivals.
		for (i = 0; i < TABLE_DEPTH + 2; i++)
			send_item(make_item(ACT_POST, 0, '0, '0, 16'h77, 0, i[15:0], 32'd100));
		for (i = 0; i < TABLE_DEPTH + 2; i++)
			send_item(make_item(ACT_ARRIVE, 0, '0, '0, 16'h77, 0, i[15:0], 32'd90 + i));
		idle_cycles(1);

		// Long receiver hold-off while items keep coming.
		fork
			begin
				long_hold <= 1;
				repeat (300) @(posedge clk);
				long_hold <= 0;
			end
			for (i = 0; i < 20; i++) send_item(random_item(1));
		join

		// Random part in bursts with gaps.
		i = 0;
		while (i < 2000) begin
			burst = $urandom_range(1, 30);
			repeat (burst) begin
				it = random_item($urandom_range(0, 9) != 0);
				send_item(it);
				i++;
			end
			if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
		end
		in_valid <= 0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Covered posts and arrivals of both classes with %0d matches and %0d drops.",
			sb.hit_count, sb.drops);
		if (sb.errors == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end
endmodule
